FILE: rtl/cpct_pkg.sv
// ----------------------------------------------------------------------------
// cpct_pkg
// Types and constants shared by the circle pair collision test pipeline.
// ----------------------------------------------------------------------------
package cpct_pkg;

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 15;
  localparam logic [14:0] UNIT_Q14 = 15'd16384;
  localparam logic [45:0] HALF_Q14 = 46'd8192;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [30:0]        ra;
    logic [31:0]        rsum;
    logic               sgx;
    logic               sgy;
    logic [31:0]        mx;
    logic [31:0]        my;
    logic               coll;
    logic [31:0]        pen;
    logic               dz;
  } carry_t;

endpackage

FILE: rtl/circle_pair_collision_test.sv
// ----------------------------------------------------------------------------
// circle_pair_collision_test
// Throughput is one transaction per cycle while the output is not stalled;
// the 32-step root and two 15-step dividers are fully pipelined, one step
// per stage.
// A stall at the output freezes every stage together.
// Reset (synchronous, active high) clears all stage valid bits.
// ----------------------------------------------------------------------------
module circle_pair_collision_test
  import cpct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] center_a_x,
  input  logic signed [31:0] center_a_y,
  input  logic [30:0]        radius_a,
  input  logic signed [31:0] center_b_x,
  input  logic signed [31:0] center_b_y,
  input  logic [30:0]        radius_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               colliding,
  output logic [31:0]        penetration,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [31:0] contact_x,
  output logic signed [31:0] contact_y
);

  localparam int NST = 3 + SQ_STEPS + 1 + DIV_STEPS + 2;

  logic [NST-1:0] vld;
  logic           adv;

  assign adv      = !vld[NST-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // Stage 1: differences and radius sum.
  carry_t      c1, c1_next;
  logic [32:0] m1x, m1y;
  logic signed [32:0] dx, dy;

  assign dx = 33'(center_b_x) - 33'(center_a_x);
  assign dy = 33'(center_b_y) - 33'(center_a_y);

  always_comb begin
    c1_next      = '0;
    c1_next.ax   = center_a_x;
    c1_next.ay   = center_a_y;
    c1_next.ra   = radius_a;
    c1_next.rsum = 32'(radius_a) + 32'(radius_b);
    c1_next.sgx  = dx[32];
    c1_next.sgy  = dy[32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1  <= c1_next;
      m1x <= dx[32] ? 33'(-dx) : 33'(dx);
      m1y <= dy[32] ? 33'(-dy) : 33'(dy);
    end
  end

  // Stage 2: squares.
  carry_t      c2, c2_next;
  logic [63:0] sx, sy, rsq;
  logic        far;

  always_comb begin
    c2_next    = c1;
    c2_next.mx = m1x[31:0];
    c2_next.my = m1y[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2    <= c2_next;
      far   <= (m1x >= {1'b0, c1.rsum}) || (m1y >= {1'b0, c1.rsum});
      sx    <= 64'(m1x[31:0]) * 64'(m1x[31:0]);
      sy    <= 64'(m1y[31:0]) * 64'(m1y[31:0]);
      rsq   <= 64'(c1.rsum) * 64'(c1.rsum);
    end
  end

  // Stage 3: overlap test.
  carry_t      c3, c3_next;
  logic [64:0] ssum;
  logic [63:0] ssq;
  assign ssum = {1'b0, sx} + {1'b0, sy};

  always_comb begin
    c3_next      = c2;
    c3_next.coll = !far && (ssum < {1'b0, rsq});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3  <= c3_next;
      ssq <= ssum[63:0];
    end
  end

  // Square root, one result bit per stage.
  carry_t      sq_c [SQ_STEPS];
  logic [63:0] sq_x [SQ_STEPS];
  logic [33:0] sq_r [SQ_STEPS];
  logic [31:0] sq_q [SQ_STEPS];
  logic [63:0] sqn_x [SQ_STEPS];
  logic [33:0] sqn_r [SQ_STEPS];
  logic [31:0] sqn_q [SQ_STEPS];

  always_comb begin
    logic [63:0] xi;
    logic [33:0] ri;
    logic [31:0] qi;
    logic [35:0] rt, tt;
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (k == 0) begin
        xi = ssq;
        ri = '0;
        qi = '0;
      end else begin
        xi = sq_x[k-1];
        ri = sq_r[k-1];
        qi = sq_q[k-1];
      end
      rt = {ri, xi[63:62]};
      tt = {2'b00, qi, 2'b01};
      sqn_x[k] = {xi[61:0], 2'b00};
      if (rt >= tt) begin
        sqn_r[k] = 34'(rt - tt);
        sqn_q[k] = {qi[30:0], 1'b1};
      end else begin
        sqn_r[k] = rt[33:0];
        sqn_q[k] = {qi[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_c[k] <= (k == 0) ? c3 : sq_c[k-1];
        sq_x[k] <= sqn_x[k];
        sq_r[k] <= sqn_r[k];
        sq_q[k] <= sqn_q[k];
      end
    end
  end

  // Divider setup: round(m * 16384 / dist) as (m * 32768 + dist) / (2 * dist).
  carry_t      c4, c4_next;
  logic [32:0] dd;
  logic [32:0] r4x, r4y;
  logic [14:0] l4x, l4y;
  logic [31:0] dlen;
  logic [47:0] nnx, nny;

  assign dlen = sq_q[SQ_STEPS-1];
  assign nnx  = {1'b0, sq_c[SQ_STEPS-1].mx, 15'b0} + 48'(dlen);
  assign nny  = {1'b0, sq_c[SQ_STEPS-1].my, 15'b0} + 48'(dlen);

  always_comb begin
    c4_next     = sq_c[SQ_STEPS-1];
    c4_next.pen = sq_c[SQ_STEPS-1].rsum - dlen;
    c4_next.dz  = (dlen == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c4     <= c4_next;
      dd     <= {dlen, 1'b0};
      r4x    <= nnx[47:15];
      r4y    <= nny[47:15];
      l4x    <= nnx[14:0];
      l4y    <= nny[14:0];
    end
  end

  carry_t      dv_c  [DIV_STEPS];
  logic [32:0] dv_d  [DIV_STEPS];
  logic [32:0] dv_rx [DIV_STEPS];
  logic [32:0] dv_ry [DIV_STEPS];
  logic [14:0] dv_lx [DIV_STEPS];
  logic [14:0] dv_ly [DIV_STEPS];
  logic [14:0] dv_qx [DIV_STEPS];
  logic [14:0] dv_qy [DIV_STEPS];
  logic [32:0] dvn_rx [DIV_STEPS];
  logic [32:0] dvn_ry [DIV_STEPS];
  logic [14:0] dvn_qx [DIV_STEPS];
  logic [14:0] dvn_qy [DIV_STEPS];

  always_comb begin
    logic [32:0] d, rx, ry;
    logic [14:0] lx, ly, qx, qy;
    logic [33:0] tx, ty;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        d = dd; rx = r4x; ry = r4y; lx = l4x; ly = l4y; qx = '0; qy = '0;
      end else begin
        d = dv_d[j-1]; rx = dv_rx[j-1]; ry = dv_ry[j-1];
        lx = dv_lx[j-1]; ly = dv_ly[j-1]; qx = dv_qx[j-1]; qy = dv_qy[j-1];
      end
      tx = {rx, lx[14]};
      ty = {ry, ly[14]};
      if (tx >= {1'b0, d}) begin
        dvn_rx[j] = 33'(tx - {1'b0, d});
        dvn_qx[j] = {qx[13:0], 1'b1};
      end else begin
        dvn_rx[j] = tx[32:0];
        dvn_qx[j] = {qx[13:0], 1'b0};
      end
      if (ty >= {1'b0, d}) begin
        dvn_ry[j] = 33'(ty - {1'b0, d});
        dvn_qy[j] = {qy[13:0], 1'b1};
      end else begin
        dvn_ry[j] = ty[32:0];
        dvn_qy[j] = {qy[13:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_c[j]  <= (j == 0) ? c4 : dv_c[j-1];
        dv_d[j]  <= (j == 0) ? dd : dv_d[j-1];
        dv_lx[j] <= (j == 0) ? {l4x[13:0], 1'b0} : {dv_lx[j-1][13:0], 1'b0};
        dv_ly[j] <= (j == 0) ? {l4y[13:0], 1'b0} : {dv_ly[j-1][13:0], 1'b0};
        dv_rx[j] <= dvn_rx[j];
        dv_ry[j] <= dvn_ry[j];
        dv_qx[j] <= dvn_qx[j];
        dv_qy[j] <= dvn_qy[j];
      end
    end
  end

  // Normal and offset products.
  carry_t      c5;
  logic [14:0] ux, uy;
  logic [45:0] px, py;
  logic signed [15:0] n5x, n5y;
  carry_t      cd;

  assign cd = dv_c[DIV_STEPS-1];
  assign ux = cd.dz ? UNIT_Q14 : dv_qx[DIV_STEPS-1];
  assign uy = cd.dz ? 15'd0 : dv_qy[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      c5  <= cd;
      n5x <= cd.sgx ? -$signed({1'b0, ux}) : $signed({1'b0, ux});
      n5y <= cd.sgy ? -$signed({1'b0, uy}) : $signed({1'b0, uy});
      px  <= 46'(ux) * 46'(cd.ra);
      py  <= 46'(uy) * 46'(cd.ra);
    end
  end

  // Contact point with saturation, output register.
  logic [31:0] ox, oy;
  logic signed [33:0] sx34, sy34;
  logic signed [31:0] csx, csy;

  assign ox = 32'((px + HALF_Q14) >> 14);
  assign oy = 32'((py + HALF_Q14) >> 14);
  assign sx34 = n5x[15] ? 34'(c5.ax) - $signed({2'b00, ox})
                        : 34'(c5.ax) + $signed({2'b00, ox});
  assign sy34 = n5y[15] ? 34'(c5.ay) - $signed({2'b00, oy})
                        : 34'(c5.ay) + $signed({2'b00, oy});

  always_comb begin
    if (sx34 > 34'sh0_7FFF_FFFF) begin
      csx = 32'sh7FFF_FFFF;
    end else if (sx34 < -34'sh0_8000_0000) begin
      csx = 32'sh8000_0000;
    end else begin
      csx = sx34[31:0];
    end
    if (sy34 > 34'sh0_7FFF_FFFF) begin
      csy = 32'sh7FFF_FFFF;
    end else if (sy34 < -34'sh0_8000_0000) begin
      csy = 32'sh8000_0000;
    end else begin
      csy = sy34[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      colliding   <= c5.coll;
      penetration <= c5.coll ? c5.pen : '0;
      normal_x    <= c5.coll ? n5x : '0;
      normal_y    <= c5.coll ? n5y : '0;
      contact_x   <= c5.coll ? csx : '0;
      contact_y   <= c5.coll ? csy : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !colliding |-> penetration == '0 && normal_x == '0 &&
      normal_y == '0 && contact_x == '0 && contact_y == '0)
    else $error("non-colliding result carries nonzero fields");

  a_pen_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && colliding |-> penetration != '0)
    else $error("collision reported with zero penetration");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && colliding |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
      normal_y <= 16'sd16384 && normal_y >= -16'sd16384)
    else $error("normal component out of range");

endmodule

FILE: test/circle_pair_collision_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_pair_collision_test_tb
// Sends circle pairs through the collision pipeline and checks every result
// against a predictor of the overlap, depth, normal and contact point.
// ----------------------------------------------------------------------------
module circle_pair_collision_test_tb;
  import cpct_pkg::*;

  typedef struct {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [30:0] ra;
    logic [31:0] bx;
    logic [31:0] by;
    logic [30:0] rb;
  } pair_t;

  typedef struct {
    logic        coll;
    logic [31:0] pen;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [31:0] cx;
    logic [31:0] cy;
  } contact_t;

  class collision_scoreboard;
    contact_t pending[$];
    int errors = 0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned rem, root, b;
      rem = x;
      root = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem = rem - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    function automatic longint unit_part(longint d, longint unsigned dlen);
      longint unsigned m, q;
      m = d < 0 ? -d : d;
      q = (m * 32768 + dlen) / (2 * dlen);
      return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint touch_point(longint c, longint n, longint unsigned r);
      longint unsigned m, p;
      longint s;
      m = n < 0 ? -n : n;
      p = (m * r + 8192) / 16384;
      s = c + (n < 0 ? -longint'(p) : longint'(p));
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
    endfunction

    function void note_pair(pair_t p);
      contact_t e;
      longint ax, ay, dx, dy, nx, ny;
      longint unsigned rsum, mx, my, sx, sy, dlen;
      e = '{1'b0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0};
      ax = longint'($signed(p.ax));
      ay = longint'($signed(p.ay));
      dx = longint'($signed(p.bx)) - ax;
      dy = longint'($signed(p.by)) - ay;
      rsum = longint'(p.ra) + longint'(p.rb);
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      if (mx < rsum && my < rsum) begin
        sx = mx * mx;
        sy = my * my;
        if (sy < rsum * rsum - sx) begin
          dlen = int_sqrt(sx + sy);
          if (dlen > 0) begin
            nx = unit_part(dx, dlen);
            ny = unit_part(dy, dlen);
          end else begin
            nx = 16384;
            ny = 0;
          end
          e.coll = 1'b1;
          e.pen = 32'(rsum - dlen);
          e.nx = 16'(nx);
          e.ny = 16'(ny);
          e.cx = 32'(touch_point(ax, nx, p.ra));
          e.cy = 32'(touch_point(ay, ny, p.ra));
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(contact_t a);
      contact_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transaction", $realtime);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.coll !== e.coll) begin
        $display("%0t: colliding expected %0h actual %0h", $realtime, e.coll, a.coll);
        errors++;
      end
      if (a.pen !== e.pen) begin
        $display("%0t: penetration expected %0h actual %0h", $realtime, e.pen, a.pen);
        errors++;
      end
      if (a.nx !== e.nx) begin
        $display("%0t: normal_x expected %0h actual %0h", $realtime, e.nx, a.nx);
        errors++;
      end
      if (a.ny !== e.ny) begin
        $display("%0t: normal_y expected %0h actual %0h", $realtime, e.ny, a.ny);
        errors++;
      end
      if (a.cx !== e.cx) begin
        $display("%0t: contact_x expected %0h actual %0h", $realtime, e.cx, a.cx);
        errors++;
      end
      if (a.cy !== e.cy) begin
        $display("%0t: contact_y expected %0h actual %0h", $realtime, e.cy, a.cy);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] center_a_x = '0;
  logic signed [31:0] center_a_y = '0;
  logic [30:0]        radius_a = '0;
  logic signed [31:0] center_b_x = '0;
  logic signed [31:0] center_b_y = '0;
  logic [30:0]        radius_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               colliding;
  logic [31:0]        penetration;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [31:0] contact_x;
  logic signed [31:0] contact_y;

  collision_scoreboard board = new();
  bit     sending_done = 1'b0;
  bit     hold_output = 1'b0;
  longint cycle_count = 0;

  circle_pair_collision_test u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .center_a_x(center_a_x), .center_a_y(center_a_y), .radius_a(radius_a),
    .center_b_x(center_b_x), .center_b_y(center_b_y), .radius_b(radius_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .colliding(colliding), .penetration(penetration),
    .normal_x(normal_x), .normal_y(normal_y),
    .contact_x(contact_x), .contact_y(contact_y)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_pair(pair_t p, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    center_a_x <= p.ax;
    center_a_y <= p.ay;
    radius_a <= p.ra;
    center_b_x <= p.bx;
    center_b_y <= p.by;
    radius_b <= p.rb;
    do @(posedge clk); while (!in_ready);
    board.note_pair(p);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 100000)
                                      : 32'h80000000 + $urandom_range(0, 100000);
      default: return 32'($signed($urandom_range(0, 800)) - 400) <<< 16;
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 32'h40000000));
      2: return 31'($urandom_range(0, 2000000));
      default: return 31'($urandom_range(0, 300)) << 16;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    logic [31:0] span;
    p.ax = rand_coord();
    p.ay = rand_coord();
    p.ra = rand_radius();
    p.rb = rand_radius();
    if ($urandom_range(0, 3) != 0) begin
      span = 32'(p.ra) + 32'(p.rb) + 1;
      if (span > 32'h7FFFFFFF) span = 32'h7FFFFFFF;
      p.bx = p.ax + 32'($signed($urandom_range(0, span)) - $signed(span >> 1));
      p.by = p.ay + 32'($signed($urandom_range(0, span)) - $signed(span >> 1));
    end else begin
      p.bx = rand_coord();
      p.by = rand_coord();
    end
    return p;
  endfunction

  initial begin
    pair_t directed[$];
    pair_t p;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed.push_back('{32'd0, 32'd0, 31'h10000, 32'd0, 32'd0, 31'h10000});
    directed.push_back('{32'd0, 32'd0, 31'd0, 32'd0, 32'd0, 31'd0});
    directed.push_back('{32'd0, 32'd0, 31'h10000, 32'h18000, 32'd0, 31'h10000});
    directed.push_back('{32'd0, 32'd0, 31'h10000, 32'h20000, 32'd0, 31'h10000});
    directed.push_back('{32'd0, 32'd0, 31'h10000, 32'h1FFFF, 32'd0, 31'h10000});
    directed.push_back('{32'h10000, 32'h10000, 31'h10000, 32'h0, 32'h0, 31'h10000});
    directed.push_back('{32'd0, 32'd0, 31'h20000, 32'hFFFF0000, 32'h10000, 31'h10000});
    directed.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                         32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF});
    directed.push_back('{32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                         32'h80000000, 32'h80000001, 31'h7FFFFFFF});
    directed.push_back('{32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                         32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF});
    directed.push_back('{32'h7FFFFFF0, 32'd0, 31'h40000000, 32'h7FFFFFFF, 32'd0, 31'h10});
    directed.push_back('{32'h80000010, 32'd0, 31'h40000000, 32'h80000000, 32'd0, 31'h10});
    directed.push_back('{32'd0, 32'h7FFFFFF0, 31'h40000000, 32'd0, 32'h7FFFFFFF, 31'h10});
    directed.push_back('{32'd0, 32'h80000010, 31'h40000000, 32'd0, 32'h80000000, 31'h10});
    directed.push_back('{32'd0, 32'd0, 31'h40000000, 32'd3, 32'd4, 31'h40000000});
    directed.push_back('{32'd5, 32'd5, 31'h1, 32'd5, 32'd5, 31'h0});
    directed.push_back('{32'd0, 32'd0, 31'd1, 32'd1, 32'd0, 31'd0});
    directed.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 31'h55555555,
                         32'h00000000, 32'h00000000, 31'h2AAAAAAA});
    foreach (directed[i]) send_pair(directed[i], 0);
    for (int i = 0; i < 1750; i++) begin
      p = rand_pair();
      if (i == 300) hold_output = 1'b1;
      send_pair(p, (i > 300 && i < 500) ? 0 : $urandom_range(0, 9));
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result('{colliding, penetration, normal_x, normal_y,
                           contact_x, contact_y});
    end
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cpct_pkg.sv
rtl/circle_pair_collision_test.sv
test/circle_pair_collision_test_tb.sv
